// File: hdl/mpq_pkg.sv
package mpq_pkg;

   // Store geometry
   localparam int DEPTH   = 8;
   localparam int SLOT_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 4;
   localparam int CAP_W    = 4;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Width used to compare the count against the capacity
   localparam int CMP_W = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

   // Request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Register indexes (word address)
   localparam logic REG_CAPACITY = 1'b0;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INS  = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   // Control into the compare unit
   typedef struct packed {
      logic              clear;
      logic              valid;
      logic              held;
      logic [SLOT_W-1:0] slot;
   } cmp_ctl_type;

   // Running minimum out of the compare unit
   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
   } min_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } free_type;

   // Lowest clear bit of the occupancy mask
   function automatic free_type first_free(input logic [DEPTH-1:0] mask);
      free_type res;
      res.found = 1'b0;
      res.slot  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!mask[i]) begin
            res.found = 1'b1;
            res.slot  = SLOT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

// File: hdl/mpq_ram.sv
module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mpq_min_unit.sv
module mpq_min_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  mpq_pkg::cmp_ctl_type         ctl,
   input  logic [mpq_pkg::VALUE_W-1:0]  data,
   output mpq_pkg::min_type             best
);

   logic                        found_ff, found_in;
   logic [mpq_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [mpq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        take;

   // Strict less-than keeps the lowest slot among equal minima
   assign take = ctl.valid && ctl.held &&
                 (!found_ff || ($signed(data) < $signed(value_ff)));

   always_comb begin
      found_in = found_ff;
      slot_in  = slot_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         slot_in  = ctl.slot;
         value_in = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      slot_ff  <= slot_in;
      value_ff <= value_in;
   end

   assign best.found = found_ff;
   assign best.slot  = slot_ff;
   assign best.value = value_ff;

endmodule

// File: hdl/min_priority_queue.sv
// Bounded min-priority queue of signed 32-bit values, each value its own priority.
// A request is taken when start is high and busy is low; its result shows on the
// rsp_ ports for one cycle with rsp_strobe, and the receiver cannot stall it, so it
// must take every strobe. Busy stays high from acceptance until the result is
// registered, so the next request is taken no earlier than the cycle the result
// shows. Insert passes through ST_INS; remove and peek scan every slot in ST_SCAN
// and finish in ST_WAIT and ST_FIN, because one comparator walks the entry RAM's
// single read port one slot per cycle. An unknown request code answers on the
// next cycle with no busy time. capacity_limit (APB, address 0) may only be
// written while no request is in flight.
module min_priority_queue (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [mpq_pkg::REQ_W-1:0]      req_type,
   input  logic [mpq_pkg::VALUE_W-1:0]    req_item_value,
   // result channel
   output logic                           rsp_strobe,
   output logic [mpq_pkg::VALUE_W-1:0]    rsp_result_value,
   output logic [mpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mpq_pkg::HELD_W-1:0]     rsp_held_count,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mpq_pkg::CSR_AW-1:0]     paddr,
   input  logic [mpq_pkg::CSR_DW-1:0]     pwdata,
   output logic [mpq_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);

   mpq_pkg::state_type             state_ff, state_in;
   logic [mpq_pkg::REQ_W-1:0]      op_ff, op_in;
   logic [mpq_pkg::VALUE_W-1:0]    item_ff, item_in;
   logic [mpq_pkg::SLOT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [mpq_pkg::SLOT_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [mpq_pkg::DEPTH-1:0]      occ_ff, occ_in;
   logic [mpq_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [mpq_pkg::CAP_W-1:0]      cap_ff, cap_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mpq_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [mpq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [mpq_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                           accept;
   logic                           csr_wr;
   logic                           at_cap;
   logic                           ram_we;
   logic [mpq_pkg::VALUE_W-1:0]    ram_rd_data;
   mpq_pkg::free_type              free_slot;
   mpq_pkg::cmp_ctl_type           cmp_ctl;
   mpq_pkg::min_type               best;

   assign accept = start && !busy;
   assign busy   = (state_ff != mpq_pkg::ST_IDLE);

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign cap_in = (csr_wr && (paddr[2] == mpq_pkg::REG_CAPACITY))
                   ? pwdata[mpq_pkg::CAP_W-1:0] : cap_ff;
   assign prdata = (paddr[2] == mpq_pkg::REG_CAPACITY)
                   ? mpq_pkg::CSR_DW'(cap_ff) : '0;

   // Full when count reaches the capacity or the store depth
   assign at_cap = (mpq_pkg::CMP_W'(count_ff) >= mpq_pkg::CMP_W'(cap_ff)) ||
                   (mpq_pkg::CMP_W'(count_ff) >= mpq_pkg::CMP_W'(mpq_pkg::DEPTH));
   assign free_slot = mpq_pkg::first_free(occ_ff);

   // Entry store
   assign ram_we = (state_ff == mpq_pkg::ST_INS) && !at_cap && free_slot.found;

   mpq_ram #(
      .WIDTH (mpq_pkg::VALUE_W),
      .DEPTH (mpq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_slot.slot),
      .wr_data (item_ff),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Shared comparator
   assign cmp_ctl.clear = accept;
   assign cmp_ctl.valid = rd_valid_ff;
   assign cmp_ctl.held  = occ_ff[rd_slot_ff];
   assign cmp_ctl.slot  = rd_slot_ff;

   mpq_min_unit u_min (
      .clock (clock),
      .reset (reset),
      .ctl   (cmp_ctl),
      .data  (ram_rd_data),
      .best  (best)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      item_in       = item_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      rd_slot_in    = scan_idx_ff;
      occ_in        = occ_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         mpq_pkg::ST_IDLE: begin
            if (accept) begin
               op_in       = req_type;
               item_in     = req_item_value;
               scan_idx_in = '0;
               if (req_type == mpq_pkg::REQ_INSERT) begin
                  state_in = mpq_pkg::ST_INS;
               end else if (req_type == mpq_pkg::REQ_REMOVE ||
                            req_type == mpq_pkg::REQ_PEEK) begin
                  state_in = mpq_pkg::ST_SCAN;
               end else begin
                  // unknown code: answer at once, nothing changes
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = mpq_pkg::STATUS_OK;
                  rsp_count_in  = count_ff;
               end
            end
         end
         mpq_pkg::ST_INS: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            if (ram_we) begin
               occ_in[free_slot.slot] = 1'b1;
               count_in      = count_ff + mpq_pkg::COUNT_W'(1);
               rsp_status_in = mpq_pkg::STATUS_OK;
               rsp_count_in  = count_ff + mpq_pkg::COUNT_W'(1);
            end else begin
               rsp_status_in = mpq_pkg::STATUS_FULL;
               rsp_count_in  = count_ff;
            end
            state_in = mpq_pkg::ST_IDLE;
         end
         mpq_pkg::ST_SCAN: begin
            // one read address per cycle, data compared in the following cycle
            rd_valid_in = 1'b1;
            if (scan_idx_ff == mpq_pkg::SLOT_W'(mpq_pkg::DEPTH - 1)) begin
               state_in = mpq_pkg::ST_WAIT;
            end else begin
               scan_idx_in = scan_idx_ff + mpq_pkg::SLOT_W'(1);
            end
         end
         mpq_pkg::ST_WAIT: begin
            state_in = mpq_pkg::ST_FIN;
         end
         mpq_pkg::ST_FIN: begin
            rsp_valid_in = 1'b1;
            if (best.found) begin
               rsp_value_in  = best.value;
               rsp_status_in = mpq_pkg::STATUS_OK;
               if (op_ff == mpq_pkg::REQ_REMOVE) begin
                  occ_in[best.slot] = 1'b0;
                  count_in     = count_ff - mpq_pkg::COUNT_W'(1);
                  rsp_count_in = count_ff - mpq_pkg::COUNT_W'(1);
               end else begin
                  rsp_count_in = count_ff;
               end
            end else begin
               rsp_value_in  = '0;
               rsp_status_in = mpq_pkg::STATUS_EMPTY;
               rsp_count_in  = count_ff;
            end
            state_in = mpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         occ_ff       <= '0;
         count_ff     <= '0;
         cap_ff       <= mpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      item_ff       <= item_in;
      scan_idx_ff   <= scan_idx_in;
      rd_slot_ff    <= rd_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Result ports
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_held_count   = mpq_pkg::HELD_W'(rsp_count_ff);

   // Count tracks the occupancy mask
   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == 32'(count_ff))
      else $error("entry count differs from occupancy mask");

   // A result never appears while a request is still being worked
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Empty only when nothing is held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == mpq_pkg::STATUS_EMPTY) |-> (rsp_held_count == '0))
      else $error("empty status with entries held");

   // Insert answers by way of the ST_INS state after acceptance
   a_insert_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == mpq_pkg::REQ_INSERT) |=> ##1 rsp_strobe)
      else $error("insert result missing");

   // Store write only on an insert with room
   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < mpq_pkg::COUNT_W'(mpq_pkg::DEPTH)))
      else $error("write into a full store");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

   // request code with no operation behind it
   localparam logic [mpq_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int PHASES          = 11;
   localparam int DRAIN_CYCLES    = 2 * mpq_pkg::DEPTH + 8;

   typedef struct packed {
      logic [mpq_pkg::VALUE_W-1:0]  value;
      logic [mpq_pkg::STATUS_W-1:0] status;
      logic [mpq_pkg::HELD_W-1:0]   count;
   } response_type;

   typedef struct packed {
      logic [mpq_pkg::REQ_W-1:0]   kind;
      logic [mpq_pkg::VALUE_W-1:0] value;
      logic                        typed;
      response_type                want;
   } stim_row_type;

   // directed requests; typed rows carry their response, the rest use the predictor
   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED[DIRECTED_ROWS] = '{
      '{mpq_pkg::REQ_PEEK,   32'h0000_0000, 1'b1, '{32'h0, mpq_pkg::STATUS_EMPTY, 4'd0}},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, mpq_pkg::STATUS_EMPTY, 4'd0}},
      '{REQ_UNKNOWN,         32'h1234_5678, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd0}},
      '{mpq_pkg::REQ_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd1}},
      '{mpq_pkg::REQ_INSERT, 32'h8000_0000, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd2}},
      '{mpq_pkg::REQ_PEEK,   32'h0000_0000, 1'b1,
        '{32'h8000_0000, mpq_pkg::STATUS_OK, 4'd2}},
      '{mpq_pkg::REQ_INSERT, 32'h0000_0000, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd3}},
      '{mpq_pkg::REQ_INSERT, 32'hffff_ffff, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd4}},
      '{mpq_pkg::REQ_INSERT, 32'h0000_0005, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd5}},
      '{mpq_pkg::REQ_INSERT, 32'h0000_0005, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd6}},
      '{mpq_pkg::REQ_INSERT, 32'haaaa_aaaa, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd7}},
      '{mpq_pkg::REQ_INSERT, 32'h5555_5555, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd8}},
      '{mpq_pkg::REQ_INSERT, 32'h0000_0001, 1'b1, '{32'h0, mpq_pkg::STATUS_FULL,  4'd8}},
      '{REQ_UNKNOWN,         32'hffff_ffff, 1'b1, '{32'h0, mpq_pkg::STATUS_OK,    4'd8}},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b1,
        '{32'h8000_0000, mpq_pkg::STATUS_OK, 4'd7}},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_INSERT, 32'h8000_0001, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{mpq_pkg::REQ_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, mpq_pkg::STATUS_EMPTY, 4'd0}}
   };

   // capacity per random phase: reset value, extremes, and drops below the count
   localparam logic [mpq_pkg::CAP_W-1:0] CAP_PLAN[PHASES] = '{
      4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd2, 4'd8, 4'd5, 4'd7, 4'd4, 4'd8
   };

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [mpq_pkg::REQ_W-1:0]    req_type;
   logic [mpq_pkg::VALUE_W-1:0]  req_item_value;
   logic                         rsp_strobe;
   logic [mpq_pkg::VALUE_W-1:0]  rsp_result_value;
   logic [mpq_pkg::STATUS_W-1:0] rsp_status;
   logic [mpq_pkg::HELD_W-1:0]   rsp_held_count;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [mpq_pkg::CSR_AW-1:0]   paddr;
   logic [mpq_pkg::CSR_DW-1:0]   pwdata;
   logic [mpq_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   // shadow copy of the queue and its capacity register
   logic signed [mpq_pkg::VALUE_W-1:0] shadow_vals [mpq_pkg::DEPTH];
   logic [mpq_pkg::DEPTH-1:0]          shadow_mask;
   int                                 shadow_count;
   logic [mpq_pkg::CAP_W-1:0]          shadow_cap;

   response_type due_responses[$];
   int           error_count;
   int           cycle_count = 0;

   min_priority_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_held_count   (rsp_held_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // apply one request to the shadow queue and return the response it yields
   function automatic response_type serve_request(
         input logic [mpq_pkg::REQ_W-1:0] kind,
         input logic [mpq_pkg::VALUE_W-1:0] val);
      response_type r;
      int           room;
      int           slot;
      r = '0;
      r.status = mpq_pkg::STATUS_OK;
      room = (shadow_cap > mpq_pkg::DEPTH) ? mpq_pkg::DEPTH : int'(shadow_cap);
      slot = -1;
      case (kind)
         mpq_pkg::REQ_INSERT: begin
            for (int i = mpq_pkg::DEPTH - 1; i >= 0; i--)
               if (!shadow_mask[i]) slot = i;
            if (shadow_count >= room || slot < 0) begin
               r.status = mpq_pkg::STATUS_FULL;
            end else begin
               shadow_vals[slot] = val;
               shadow_mask[slot] = 1'b1;
               shadow_count++;
            end
         end
         mpq_pkg::REQ_REMOVE, mpq_pkg::REQ_PEEK: begin
            // lowest slot wins among equal minima
            for (int i = 0; i < mpq_pkg::DEPTH; i++)
               if (shadow_mask[i] && (slot < 0 || shadow_vals[i] < shadow_vals[slot]))
                  slot = i;
            if (slot < 0) begin
               r.status = mpq_pkg::STATUS_EMPTY;
            end else begin
               r.value = shadow_vals[slot];
               if (kind == mpq_pkg::REQ_REMOVE) begin
                  shadow_mask[slot] = 1'b0;
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      r.count = mpq_pkg::HELD_W'(shadow_count);
      return r;
   endfunction

   // value mix: extremes, a narrow band for equal minima, and full range
   function automatic logic [mpq_pkg::VALUE_W-1:0] pick_value();
      logic [mpq_pkg::VALUE_W-1:0] v;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         1, 2: v = 32'($urandom_range(0, 16)) - 32'd8;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // drive one request, with an optional idle burst first, and wait until taken
   task automatic issue_request(input logic [mpq_pkg::REQ_W-1:0] kind,
                                input logic [mpq_pkg::VALUE_W-1:0] val,
                                input bit idle_ok,
                                input bit typed, input response_type want);
      response_type pred;
      int           gap;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          = 1'b1;
      req_type       = kind;
      req_item_value = val;
      do @(posedge clock); while (busy);
      pred = serve_request(kind, val);
      due_responses.push_back(typed ? want : pred);
   endtask

   task automatic read_capacity(input logic [mpq_pkg::CAP_W-1:0] want);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {mpq_pkg::REG_CAPACITY, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      check_field("capacity readback", mpq_pkg::CSR_DW'(want), prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // write the capacity once the queue has answered everything, then read it back
   task automatic write_capacity(input logic [mpq_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      start = 1'b0;
      while (due_responses.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {mpq_pkg::REG_CAPACITY, 2'b00};
      pwdata  = mpq_pkg::CSR_DW'(cap);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      shadow_cap = cap;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      read_capacity(cap);
   endtask

   // response checker
   always @(posedge clock) begin
      response_type head;
      if (!reset && rsp_strobe) begin
         if (due_responses.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, actual value %h status %0d",
                     $time, rsp_result_value, rsp_status);
            $display("%0t: unexpected response count %0d", $time, rsp_held_count);
         end else begin
            head = due_responses.pop_front();
            check_field("result_value", head.value, rsp_result_value);
            check_field("status", 32'(head.status), 32'(rsp_status));
            check_field("held_count", 32'(head.count), 32'(rsp_held_count));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [mpq_pkg::REQ_W-1:0] kind;
      int                        ins_pct;
      int                        r;
      bit                        idling;
      start          = 1'b0;
      req_type       = mpq_pkg::REQ_INSERT;
      req_item_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      error_count    = 0;
      shadow_mask    = '0;
      shadow_count   = 0;
      shadow_cap     = mpq_pkg::CAP_RESET;
      for (int i = 0; i < mpq_pkg::DEPTH; i++) shadow_vals[i] = '0;

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      read_capacity(mpq_pkg::CAP_RESET);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         issue_request(DIRECTED[i].kind, DIRECTED[i].value, 1'b1,
                       DIRECTED[i].typed, DIRECTED[i].want);

      // random phases, one capacity setting each; the last phase runs without idling
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(CAP_PLAN[p]);
         ins_pct = (p == 0) ? 80 : $urandom_range(25, 80);
         idling  = (p % 3 != 1) && (p != PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
               kind = mpq_pkg::REQ_INSERT;
            else if (r < 96)
               kind = ($urandom_range(0, 2) == 0) ? mpq_pkg::REQ_PEEK : mpq_pkg::REQ_REMOVE;
            else
               kind = REQ_UNKNOWN;
            issue_request(kind, pick_value(), idling, 1'b0, '0);
         end
      end

      // drain and let the block settle
      @(negedge clock);
      start = 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mpq_pkg.sv
hdl/mpq_ram.sv
hdl/mpq_min_unit.sv
hdl/min_priority_queue.sv
tb/sv/tb.sv
